### rtl/rlgs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RGBA smoothing table.
package rlgs_pkg;

    localparam int DEF_TABLE_SIZE = 256;
    localparam int CH_N           = 4;
    localparam int WEIGHT_W       = 16;
    localparam int Q_BITS         = 8;
    localparam logic [3:0] MASK_RESET = 4'hF;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_SMOOTH = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] entry_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_req;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       alpha_changed;
        logic       smooth_done;
    } t_rsp;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
        logic div_load;
        logic div_step;
    } t_lane_ctl;

endpackage

### rtl/rlgs_ram.sv
`timescale 1ns / 1ps
// Single-port-write, registered-read colour table bank.
module rlgs_ram
    import rlgs_pkg::*;
#(
    parameter int DEPTH = DEF_TABLE_SIZE,
    parameter int AW    = $clog2(DEF_TABLE_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_color        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_color        o_rdata
);

    t_color mem [DEPTH];
    t_color r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rlgs_wrom.sv
`timescale 1ns / 1ps
// Gaussian weight ROM in Q0.16, indexed by entry distance, registered read.
module rlgs_wrom
    import rlgs_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int AW         = $clog2(DEF_TABLE_SIZE)
) (
    input  logic                i_clk,
    input  logic [AW-1:0]       i_addr,
    output logic [WEIGHT_W-1:0] o_w
);

    localparam logic [63:0] TWO_SIZE = 64'(2 * TABLE_SIZE);
    localparam logic [63:0] Q31_ONE  = 64'd1 << 31;

    function automatic logic [WEIGHT_W-1:0] gauss_w(input logic [63:0] d);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] w;
        x = ((64'd9 * d * d) << 31) / TWO_SIZE;
        if (x >= (64'd16 << 31)) begin
            return '0;
        end
        y    = x >> 4;
        term = Q31_ONE;
        sum  = Q31_ONE;
        term = (term * y) >> 31;
        sum  = sum - term;
        term = ((term * y) >> 31) / 2;
        sum  = sum + term;
        term = ((term * y) >> 31) / 3;
        sum  = sum - term;
        term = ((term * y) >> 31) / 4;
        sum  = sum + term;
        term = ((term * y) >> 31) / 5;
        sum  = sum - term;
        term = ((term * y) >> 31) / 6;
        sum  = sum + term;
        term = ((term * y) >> 31) / 7;
        sum  = sum - term;
        term = ((term * y) >> 31) / 8;
        sum  = sum + term;
        term = ((term * y) >> 31) / 9;
        sum  = sum - term;
        term = ((term * y) >> 31) / 10;
        sum  = sum + term;
        term = ((term * y) >> 31) / 11;
        sum  = sum - term;
        term = ((term * y) >> 31) / 12;
        sum  = sum + term;
        for (int k = 0; k < 4; k++) begin
            sum = (sum * sum + (64'd1 << 30)) >> 31;
        end
        w = (sum + 64'd16384) >> 15;
        if (w > 64'd65535) begin
            w = 64'd65535;
        end
        return w[WEIGHT_W-1:0];
    endfunction

    logic [WEIGHT_W-1:0] rom_tbl [TABLE_SIZE];
    logic [WEIGHT_W-1:0] r_w;

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
        assign rom_tbl[g] = gauss_w(64'(g));
    end

    always_ff @(posedge i_clk) begin
        r_w <= rom_tbl[i_addr];
    end

    assign o_w = r_w;

endmodule

### rtl/rlgs_lane.sv
`timescale 1ns / 1ps
// One channel lane: weighted multiply-accumulate and bit-serial rounded divide.
module rlgs_lane
    import rlgs_pkg::*;
#(
    parameter int WSUM_W = WEIGHT_W + $clog2(DEF_TABLE_SIZE)
) (
    input  logic                i_clk,
    input  t_lane_ctl           i_ctl,
    input  logic [WEIGHT_W-1:0] i_w,
    input  logic [7:0]          i_c,
    input  logic [WSUM_W-1:0]   i_wsum,
    output logic [Q_BITS-1:0]   o_q
);

    localparam int PROD_W = WEIGHT_W + 8;
    localparam int ACC_W  = WSUM_W + 8;
    localparam int NUM_W  = WSUM_W + 9;

    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_dsh;
    logic [Q_BITS-1:0] r_q;
    logic              fits;

    assign fits = (r_num >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(i_w) * PROD_W'(i_c);
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.div_load) begin
            r_num <= NUM_W'({r_acc, 1'b0}) + NUM_W'(i_wsum);
            r_dsh <= NUM_W'({i_wsum, 1'b0}) << (Q_BITS - 1);
            r_q   <= '0;
        end else if (i_ctl.div_step) begin
            if (fits) begin
                r_num <= r_num - r_dsh;
            end
            r_q   <= {r_q[Q_BITS-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/rlgs_merge.sv
`timescale 1ns / 1ps
// Merge of lane results: masked channels take the smoothed value.
module rlgs_merge
    import rlgs_pkg::*;
(
    input  logic [CH_N*Q_BITS-1:0] i_q,
    input  t_color                 i_orig,
    input  logic [CH_N-1:0]        i_mask,
    output t_color                 o_word
);

    logic [CH_N*8-1:0] orig_bits;
    logic [CH_N*8-1:0] word_bits;

    assign orig_bits = i_orig;

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            word_bits[8*c +: 8] = i_mask[c] ? i_q[Q_BITS*c +: 8] : orig_bits[8*c +: 8];
        end
    end

    assign o_word = t_color'(word_bits);

endmodule

### rtl/rgba_lut_gaussian_smoother_unit.sv
`timescale 1ns / 1ps
// Top level: RGBA table with read, write and Gaussian smoothing sequencer.
//
//  channel | handshake                    | payload
//  --------+------------------------------+---------------------
//  request | i_in_valid  / o_in_stall     | i_in  (t_req)
//  result  | o_out_valid / i_out_stall    | o_out (t_rsp)
//  config  | i_cfg_valid / o_cfg_ready    | i_cfg_data (mask)
//
// Read and write pass through ST_RDAT or ST_WCHK before the result is put out in
// ST_PUT; an out-of-range index or an unused type goes straight to ST_PUT. A smooth
// does one table read per entry pair through the four channel lanes, then an 8-step
// divide, for each entry; the lane pipeline drains in ST_DRAIN before the divide.
// After reset a ramp fill pass writes all TABLE_SIZE entries with o_in_stall high.
// One item is worked at a time; a new one is taken while a result waits.
// Smoothing writes the spare bank and then swaps banks.
module rgba_lut_gaussian_smoother_unit
    import rlgs_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_req       i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_rsp       o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    localparam int AW     = $clog2(TABLE_SIZE);
    localparam int RW     = AW + 2;
    localparam int KW     = $clog2(Q_BITS);
    localparam int WSUM_W = WEIGHT_W + $clog2(TABLE_SIZE);

    localparam logic [AW-1:0] LAST      = AW'(TABLE_SIZE - 1);
    localparam logic [RW-1:0] SIZE_C    = RW'(TABLE_SIZE);
    localparam logic [RW-1:0] RAMP_R    = RW'(255 % TABLE_SIZE);
    localparam logic [7:0]    RAMP_Q    = 8'(255 / TABLE_SIZE);
    localparam logic [KW-1:0] LAST_STEP = KW'(Q_BITS - 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RDAT,
        ST_WCHK,
        ST_ACC,
        ST_DRAIN,
        ST_DIV,
        ST_WRITE,
        ST_PUT
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_i;
    logic [AW-1:0]       r_j;
    logic [KW-1:0]       r_k;
    logic [7:0]          r_ramp_q;
    logic [RW-1:0]       r_ramp_r;
    logic                r_cur;
    logic [3:0]          r_mask;
    t_req                r_req;
    t_rsp                r_res;
    t_rsp                r_out;
    logic                r_out_valid;
    logic                r_p1_valid;
    logic                r_p1_self;
    logic                r_p2_valid;
    logic [WSUM_W-1:0]   r_wsum;
    t_color              r_orig;

    logic [RW-1:0]       n_ramp_sum;
    logic                in_acc;
    logic                in_range;
    logic                out_free;
    logic                pipe_empty;
    logic [AW-1:0]       idx_addr;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       dist_idx;
    logic                we;
    logic                we_bank;
    logic [AW-1:0]       waddr;
    t_color              wdata;
    t_color              rdata0;
    t_color              rdata1;
    t_color              rd_word;
    logic [WEIGHT_W-1:0] w;
    t_lane_ctl           lane_ctl;
    logic [CH_N*Q_BITS-1:0] lane_q;
    logic [CH_N*8-1:0]   rd_bits;
    t_color              merged;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign in_range   = (32'(i_in.entry_index) < 32'(TABLE_SIZE));
    assign idx_addr   = AW'(i_in.entry_index);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign pipe_empty = !r_p1_valid && !r_p2_valid;
    assign n_ramp_sum = r_ramp_r + RAMP_R;
    assign rd_word    = r_cur ? rdata1 : rdata0;
    assign rd_bits    = rd_word;
    assign dist_idx   = (r_i >= r_j) ? (r_i - r_j) : (r_j - r_i);
    assign rd_addr    = (r_state == ST_IDLE) ? idx_addr : r_j;

    always_comb begin
        we      = 1'b0;
        we_bank = r_cur;
        waddr   = r_i;
        wdata   = merged;
        unique case (r_state)
            ST_INIT: begin
                we      = 1'b1;
                we_bank = 1'b0;
                wdata   = t_color'{alpha: r_ramp_q, blue: r_ramp_q,
                                   green: r_ramp_q, red: r_ramp_q};
            end
            ST_WCHK: begin
                we    = 1'b1;
                waddr = AW'(r_req.entry_index);
                wdata = t_color'{alpha: r_req.alpha_in, blue: r_req.blue_in,
                                 green: r_req.green_in, red: r_req.red_in};
            end
            ST_WRITE: begin
                we      = 1'b1;
                we_bank = !r_cur;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_comb begin
        lane_ctl.clr      = (in_acc && (i_in.req_type == REQ_SMOOTH)) || (r_state == ST_WRITE);
        lane_ctl.mul_en   = r_p1_valid;
        lane_ctl.acc_en   = r_p2_valid;
        lane_ctl.div_load = (r_state == ST_DRAIN) && pipe_empty;
        lane_ctl.div_step = (r_state == ST_DIV);
    end

    rlgs_ram #(.DEPTH(TABLE_SIZE), .AW(AW)) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (we && !we_bank),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(rdata0)
    );

    rlgs_ram #(.DEPTH(TABLE_SIZE), .AW(AW)) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (we && we_bank),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(rdata1)
    );

    rlgs_wrom #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_wrom (
        .i_clk (i_clk),
        .i_addr(dist_idx),
        .o_w   (w)
    );

    for (genvar c = 0; c < CH_N; c++) begin : g_lane
        rlgs_lane #(.WSUM_W(WSUM_W)) u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_w   (w),
            .i_c   (rd_bits[8*c +: 8]),
            .i_wsum(r_wsum),
            .o_q   (lane_q[Q_BITS*c +: Q_BITS])
        );
    end

    rlgs_merge u_merge (
        .i_q   (lane_q),
        .i_orig(r_orig),
        .i_mask(r_mask),
        .o_word(merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_ramp_q    <= '0;
            r_ramp_r    <= '0;
            r_cur       <= 1'b0;
            r_mask      <= MASK_RESET;
            r_out_valid <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p1_self   <= 1'b0;
            r_p2_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
            if ((r_state == ST_PUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_p1_valid <= (r_state == ST_ACC);
            r_p1_self  <= (r_j == r_i);
            r_p2_valid <= r_p1_valid;
            if (r_p1_valid) begin
                r_wsum <= r_wsum + WSUM_W'(w);
            end
            if (r_p1_valid && r_p1_self) begin
                r_orig <= rd_word;
            end

            unique case (r_state)
                ST_INIT: begin
                    if (n_ramp_sum >= SIZE_C) begin
                        r_ramp_r <= n_ramp_sum - SIZE_C;
                        r_ramp_q <= r_ramp_q + RAMP_Q + 8'd1;
                    end else begin
                        r_ramp_r <= n_ramp_sum;
                        r_ramp_q <= r_ramp_q + RAMP_Q;
                    end
                    if (r_i == LAST) begin
                        r_i     <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_req <= i_in;
                        r_res <= '0;
                        case (i_in.req_type)
                            REQ_WRITE: begin
                                r_state <= in_range ? ST_WCHK : ST_PUT;
                            end
                            REQ_READ: begin
                                r_state <= in_range ? ST_RDAT : ST_PUT;
                            end
                            REQ_SMOOTH: begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_wsum  <= '0;
                                r_state <= ST_ACC;
                            end
                            default: begin
                                r_state <= ST_PUT;
                            end
                        endcase
                    end
                end
                ST_RDAT: begin
                    r_res   <= t_rsp'{red_out: rd_word.red, green_out: rd_word.green,
                                      blue_out: rd_word.blue, alpha_out: rd_word.alpha,
                                      default: '0};
                    r_state <= ST_PUT;
                end
                ST_WCHK: begin
                    r_res   <= t_rsp'{alpha_changed: (rd_word.alpha != r_req.alpha_in),
                                      default: '0};
                    r_state <= ST_PUT;
                end
                ST_ACC: begin
                    if (r_j == LAST) begin
                        r_j     <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        r_k     <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == LAST_STEP) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_wsum <= '0;
                    r_j    <= '0;
                    if (r_i == LAST) begin
                        r_i     <= '0;
                        r_cur   <= !r_cur;
                        r_res   <= t_rsp'{smooth_done: 1'b1, default: '0};
                        r_state <= ST_PUT;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= ST_ACC;
                    end
                end
                ST_PUT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
